>>> hw/rtl/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared constants, types and the CRC helper of the RTU coil server.
// ----------------------------------------------------------------------------
`default_nettype none

package rcs_pkg;

	localparam int COIL_COUNT      = 8;
	localparam int REQ_STORE_BYTES = 16;

	// Coil data bytes a valid request can ever carry.
	localparam int DATA_BYTES = (COIL_COUNT + 7) / 8;
	localparam int DW         = DATA_BYTES * 8;
	// Leading request bytes that are ever read: header, byte count, coil data.
	localparam int HDR_BYTES  = (7 + DATA_BYTES < REQ_STORE_BYTES) ?
	                            7 + DATA_BYTES : REQ_STORE_BYTES;
	localparam int HI_W       = $clog2(HDR_BYTES);

	// Response body bytes (CRC excluded).
	localparam int FR_BYTES   = (3 + DATA_BYTES > 6) ? 3 + DATA_BYTES : 6;
	localparam int FI_W       = $clog2(FR_BYTES);
	localparam int FC_W       = $clog2(FR_BYTES + 2) + 1;

	localparam logic [8:0]  SEEN_MAX  = 9'd511;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] COIL_ON   = 16'hFF00;
	localparam logic [7:0]  EXC_FLAG  = 8'h80;

	localparam logic [7:0] FC_READ_COILS  = 8'h01;
	localparam logic [7:0] FC_WRITE_COIL  = 8'h05;
	localparam logic [7:0] FC_WRITE_COILS = 8'h0F;

	localparam logic [7:0] EXC_BAD_FUNC  = 8'h01;
	localparam logic [7:0] EXC_BAD_ADDR  = 8'h02;
	localparam logic [7:0] EXC_BAD_VALUE = 8'h03;

	typedef enum logic [1:0] {
		JOB_FAULT,
		JOB_READ,
		JOB_WR1,
		JOB_WRM
	} job_kind_t;

	typedef struct packed {
		job_kind_t                   kind;
		logic [7:0]                  code;
		logic [5:0][7:0]             hdr;   // request bytes 0..5
		logic [DATA_BYTES-1:0][7:0]  data;  // coil data bytes 7..
	} job_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rtu_coil_slave.sv
// ----------------------------------------------------------------------------
// rtu_coil_slave
// Modbus RTU coil server: read coils, write single coil, write coils.
// ----------------------------------------------------------------------------
// Request side is a queue write port: a beat of rx_byte/frame_end is taken
// on a clock edge with push high and full low; frame_end marks the last
// byte of a request, its CRC included (the CRC is not checked).
// Reply side is a queue read port: while empty is low, tx_byte, tx_last and
// coil_levels show the oldest reply beat and pop takes it; tx_last marks the
// high CRC byte. Frames under four bytes are counted and dropped silently.
// The last request beat is queued; the reply engine then loads the request,
// builds the reply and registers its first beat, then one reply beat per
// cycle while pop is held, the CRC folded in a byte per cycle. The engine
// takes the next request once the high CRC byte is loaded.
// A two-entry request queue lets the collector run ahead; full rises when
// both entries wait, which holds off every request beat.
// When the receiver stalls, hold the beat in the output register and the
// reply engine waits. Reset clears the coils, the byte count and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rtu_coil_slave (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] rx_byte,
	input  wire logic       frame_end,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      tx_byte,
	output logic            tx_last,
	output logic [7:0]      coil_levels
);

	rcs_pkg::job_t fj, bj;
	logic          accept, fpush, fpop, fempty;

	// Take a beat only while the request queue has room.
	assign accept = push && !full;

	rcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.frame_end (frame_end),
		.job       (fj),
		.job_push  (fpush)
	);

	rcs_job_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fpush),
		.din    (fj),
		.pop    (fpop),
		.dout   (bj),
		.full   (full),
		.empty  (fempty)
	);

	rcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (bj),
		.job_valid   (!fempty),
		.job_pop     (fpop),
		.pop         (pop),
		.empty       (empty),
		.tx_byte     (tx_byte),
		.tx_last     (tx_last),
		.coil_levels (coil_levels)
	);

endmodule

`default_nettype wire

>>> hw/rtl/rcs_front.sv
// ----------------------------------------------------------------------------
// rcs_front
// Collects request bytes, counts the frame and classifies it at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         accept,
	input  wire logic [7:0]   rx_byte,
	input  wire logic         frame_end,
	output rcs_pkg::job_t     job,
	output logic              job_push
);

	logic [8:0] count_q;
	logic [7:0] store_q [rcs_pkg::HDR_BYTES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (frame_end) count_q <= '0;
			else if (count_q != rcs_pkg::SEEN_MAX) count_q <= count_q + 9'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && count_q < 9'(rcs_pkg::HDR_BYTES))
			store_q[count_q[rcs_pkg::HI_W-1:0]] <= rx_byte;
	end

	// Request bytes as seen at the last beat; bytes past the frame read 0.
	logic [7:0] b [rcs_pkg::HDR_BYTES];
	always_comb begin
		for (int i = 0; i < rcs_pkg::HDR_BYTES; i++) begin
			if (9'(i) < count_q) b[i] = store_q[i];
			else if (9'(i) == count_q) b[i] = rx_byte;
			else b[i] = 8'h00;
		end
	end

	logic [8:0]  len;
	logic [15:0] addr, qty;
	logic [16:0] span;
	logic [13:0] need;
	logic        range_bad;
	logic [7:0]  bcb;

	assign len       = (count_q == rcs_pkg::SEEN_MAX) ? count_q : count_q + 9'd1;
	assign addr      = {b[2], b[3]};
	assign qty       = {b[4], b[5]};
	assign span      = {1'b0, addr} + {1'b0, qty};
	assign range_bad = (qty == 16'd0) || (span > 17'(rcs_pkg::COIL_COUNT));
	assign need      = 14'(({1'b0, qty} + 17'd7) >> 3);
	assign bcb       = (rcs_pkg::HDR_BYTES > 6) ? b[6 % rcs_pkg::HDR_BYTES] : 8'h00;

	always_comb begin
		job.code = 8'h00;
		for (int i = 0; i < 6; i++) job.hdr[i] = b[i];
		for (int j = 0; j < rcs_pkg::DATA_BYTES; j++)
			job.data[j] = (7 + j < rcs_pkg::HDR_BYTES) ?
			              b[(7 + j) % rcs_pkg::HDR_BYTES] : 8'h00;
		case (b[1])
			rcs_pkg::FC_READ_COILS: begin
				job.kind = rcs_pkg::JOB_READ;
				if (len < 9'd8) begin
					job.kind = rcs_pkg::JOB_FAULT; job.code = rcs_pkg::EXC_BAD_VALUE;
				end else if (range_bad) begin
					job.kind = rcs_pkg::JOB_FAULT; job.code = rcs_pkg::EXC_BAD_ADDR;
				end
			end
			rcs_pkg::FC_WRITE_COIL: begin
				job.kind = rcs_pkg::JOB_WR1;
				if (len < 9'd8) begin
					job.kind = rcs_pkg::JOB_FAULT; job.code = rcs_pkg::EXC_BAD_VALUE;
				end else if (addr >= 16'(rcs_pkg::COIL_COUNT)) begin
					job.kind = rcs_pkg::JOB_FAULT; job.code = rcs_pkg::EXC_BAD_ADDR;
				end else if (qty != 16'h0000 && qty != rcs_pkg::COIL_ON) begin
					job.kind = rcs_pkg::JOB_FAULT; job.code = rcs_pkg::EXC_BAD_VALUE;
				end
			end
			rcs_pkg::FC_WRITE_COILS: begin
				job.kind = rcs_pkg::JOB_WRM;
				if (len < 9'd9) begin
					job.kind = rcs_pkg::JOB_FAULT; job.code = rcs_pkg::EXC_BAD_VALUE;
				end else if (range_bad) begin
					job.kind = rcs_pkg::JOB_FAULT; job.code = rcs_pkg::EXC_BAD_ADDR;
				end else if ({6'd0, bcb} != need ||
				             {1'b0, len} < 10'd9 + {2'd0, bcb}) begin
					job.kind = rcs_pkg::JOB_FAULT; job.code = rcs_pkg::EXC_BAD_VALUE;
				end
			end
			default: begin
				job.kind = rcs_pkg::JOB_FAULT; job.code = rcs_pkg::EXC_BAD_FUNC;
			end
		endcase
	end

	// Frames under four bytes get no reply.
	assign job_push = accept && frame_end && (len >= 9'd4);

endmodule

`default_nettype wire

>>> hw/rtl/rcs_job_fifo.sv
// ----------------------------------------------------------------------------
// rcs_job_fifo
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_job_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rcs_pkg::job_t din,
	input  wire logic          pop,
	output rcs_pkg::job_t      dout,
	output logic               full,
	output logic               empty
);

	rcs_pkg::job_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

endmodule

`default_nettype wire

>>> hw/rtl/rcs_back.sv
// ----------------------------------------------------------------------------
// rcs_back
// Serves one request: updates the coils, builds the reply and streams it
// out with its CRC through a one-beat output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rcs_pkg::job_t job,
	input  wire logic          job_valid,
	output logic               job_pop,
	input  wire logic          pop,
	output logic               empty,
	output logic [7:0]         tx_byte,
	output logic               tx_last,
	output logic [7:0]         coil_levels
);

	typedef enum logic [2:0] {
		B_IDLE  = 3'b001,
		B_BUILD = 3'b010,
		B_SEND  = 3'b100
	} bstate_t;

	bstate_t                        state_q;
	rcs_pkg::job_t                  job_q;
	logic [rcs_pkg::COIL_COUNT-1:0] coil_q;
	logic [7:0]                     frame_q [rcs_pkg::FR_BYTES];
	logic [rcs_pkg::FC_W-1:0]       n_q, idx_q;
	logic [15:0]                    crc_q;
	logic                           out_valid_q, tx_last_q;
	logic [7:0]                     tx_byte_q, lv_q;

	assign job_pop     = (state_q == B_IDLE) && job_valid;
	assign empty       = !out_valid_q;
	assign tx_byte     = tx_byte_q;
	assign tx_last     = tx_last_q;
	assign coil_levels = lv_q;

	// Reply body and new coil state for the held request.
	logic [15:0]                    addr, qty;
	logic [rcs_pkg::DW-1:0]         cext, mask, rbits, dbits, sel, wbits;
	logic [rcs_pkg::COIL_COUNT-1:0] coil_n;
	logic [7:0]                     fr_n [rcs_pkg::FR_BYTES];
	logic [rcs_pkg::FC_W-1:0]       n_n;
	logic [7:0]                     bc;

	always_comb begin
		addr  = {job_q.hdr[2], job_q.hdr[3]};
		qty   = {job_q.hdr[4], job_q.hdr[5]};
		cext  = rcs_pkg::DW'(coil_q);
		mask  = ~({rcs_pkg::DW{1'b1}} << qty[7:0]);
		rbits = (cext >> addr[6:0]) & mask;
		dbits = job_q.data << addr[6:0];
		sel   = mask << addr[6:0];
		wbits = (cext & ~sel) | (dbits & sel);
		bc    = (qty[7:0] + 8'd7) >> 3;
		coil_n = coil_q;
		for (int i = 0; i < rcs_pkg::FR_BYTES; i++) fr_n[i] = 8'h00;
		for (int i = 0; i < 6; i++) fr_n[i] = job_q.hdr[i];
		n_n = rcs_pkg::FC_W'(6);
		case (job_q.kind)
			rcs_pkg::JOB_READ: begin
				fr_n[2] = bc;
				for (int j = 0; j < rcs_pkg::DATA_BYTES; j++)
					fr_n[3 + j] = rbits[8*j +: 8];
				n_n = rcs_pkg::FC_W'(3) + rcs_pkg::FC_W'(bc);
			end
			rcs_pkg::JOB_WR1: begin
				coil_n[addr[$clog2(rcs_pkg::COIL_COUNT)-1:0]] = (qty == rcs_pkg::COIL_ON);
			end
			rcs_pkg::JOB_WRM: begin
				coil_n = wbits[rcs_pkg::COIL_COUNT-1:0];
			end
			default: begin
				fr_n[1] = job_q.hdr[1] | rcs_pkg::EXC_FLAG;
				fr_n[2] = job_q.code;
				n_n     = rcs_pkg::FC_W'(3);
			end
		endcase
	end

	logic       ld;
	logic [7:0] nb;
	assign ld = !out_valid_q || pop;
	assign nb = frame_q[idx_q[rcs_pkg::FI_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			coil_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (job_valid) state_q <= B_BUILD;
				end
				B_BUILD: begin
					coil_q  <= coil_n;
					state_q <= B_SEND;
				end
				B_SEND: begin
					if (ld) begin
						out_valid_q <= 1'b1;
						if (idx_q == n_q + rcs_pkg::FC_W'(1)) state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) job_q <= job;
		if (state_q == B_BUILD) begin
			for (int i = 0; i < rcs_pkg::FR_BYTES; i++) frame_q[i] <= fr_n[i];
			n_q   <= n_n;
			idx_q <= '0;
			crc_q <= rcs_pkg::CRC_INIT;
		end
		if (state_q == B_SEND && ld) begin
			idx_q <= idx_q + rcs_pkg::FC_W'(1);
			lv_q  <= 8'(64'(coil_q));
			if (idx_q < n_q) begin
				tx_byte_q <= nb;
				tx_last_q <= 1'b0;
				crc_q     <= rcs_pkg::crc_byte(crc_q, nb);
			end else if (idx_q == n_q) begin
				tx_byte_q <= crc_q[7:0];
				tx_last_q <= 1'b0;
			end else begin
				tx_byte_q <= crc_q[15:8];
				tx_last_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> sim/rtu_coil_slave_check.sv
// ----------------------------------------------------------------------------
// rtu_coil_slave_check
// Watches the request and reply queues of the coil server, builds the reply
// bytes each request frame should give and compares every popped reply beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtu_coil_slave_check (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic       full,
	input  wire logic [7:0] rx_byte,
	input  wire logic       frame_end,
	input  wire logic       empty,
	input  wire logic       pop,
	input  wire logic [7:0] tx_byte,
	input  wire logic       tx_last,
	input  wire logic [7:0] coil_levels,
	output int              errors,
	output int              replies_owed
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [7:0] coils;
	} reply_beat_t;

	reply_beat_t reply_q[$];
	logic [rcs_pkg::COIL_COUNT-1:0] coils;
	logic [7:0] frame_buf[rcs_pkg::REQ_STORE_BYTES];
	int unsigned seen;

	assign replies_owed = reply_q.size();

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("mismatch %s: got %02h want %02h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic [7:0] byte_at(input int unsigned idx, input int unsigned len);
		if (idx >= len || idx >= rcs_pkg::REQ_STORE_BYTES)
			return 8'h00;
		return frame_buf[idx];
	endfunction

	// Serve a complete frame: update the coils and queue the reply bytes.
	task automatic serve_frame(input int unsigned len);
		logic [7:0] fr[16];
		int n, bc;
		logic [7:0] slave, fc, code;
		int unsigned addr, qty;
		logic [15:0] crc;
		bit faulted;
		slave = byte_at(0, len);
		fc = byte_at(1, len);
		addr = {byte_at(2, len), byte_at(3, len)};
		qty = {byte_at(4, len), byte_at(5, len)};
		faulted = 1'b0;
		code = rcs_pkg::EXC_BAD_FUNC;
		n = 0;
		if (fc == rcs_pkg::FC_READ_COILS) begin
			if (len < 8) begin
				faulted = 1'b1; code = rcs_pkg::EXC_BAD_VALUE;
			end else if (qty == 0 || addr + qty > rcs_pkg::COIL_COUNT) begin
				faulted = 1'b1; code = rcs_pkg::EXC_BAD_ADDR;
			end else begin
				bc = (qty + 7) / 8;
				fr[0] = slave; fr[1] = fc; fr[2] = bc[7:0];
				for (int i = 0; i < bc; i++) fr[3 + i] = 8'h00;
				for (int i = 0; i < qty; i++)
					if (coils[addr + i]) fr[3 + i / 8][i % 8] = 1'b1;
				n = 3 + bc;
			end
		end else if (fc == rcs_pkg::FC_WRITE_COIL) begin
			if (len < 8) begin
				faulted = 1'b1; code = rcs_pkg::EXC_BAD_VALUE;
			end else if (addr >= rcs_pkg::COIL_COUNT) begin
				faulted = 1'b1; code = rcs_pkg::EXC_BAD_ADDR;
			end else if (qty != 0 && qty != rcs_pkg::COIL_ON) begin
				faulted = 1'b1; code = rcs_pkg::EXC_BAD_VALUE;
			end else begin
				coils[addr] = (qty == rcs_pkg::COIL_ON);
				for (int i = 0; i < 6; i++) fr[i] = byte_at(i, len);
				n = 6;
			end
		end else if (fc == rcs_pkg::FC_WRITE_COILS) begin
			if (len < 9) begin
				faulted = 1'b1; code = rcs_pkg::EXC_BAD_VALUE;
			end else if (qty == 0 || addr + qty > rcs_pkg::COIL_COUNT) begin
				faulted = 1'b1; code = rcs_pkg::EXC_BAD_ADDR;
			end else begin
				bc = byte_at(6, len);
				if (bc != (qty + 7) / 8 || len < 9 + bc) begin
					faulted = 1'b1; code = rcs_pkg::EXC_BAD_VALUE;
				end else begin
					for (int i = 0; i < qty; i++)
						coils[addr + i] = byte_at(7 + i / 8, len) >> (i % 8);
					for (int i = 0; i < 6; i++) fr[i] = byte_at(i, len);
					n = 6;
				end
			end
		end else begin
			faulted = 1'b1;
		end
		if (faulted) begin
			fr[0] = slave; fr[1] = fc | rcs_pkg::EXC_FLAG; fr[2] = code;
			n = 3;
		end
		crc = rcs_pkg::CRC_INIT;
		for (int i = 0; i < n; i++) begin
			crc = crc ^ {8'h00, fr[i]};
			for (int b = 0; b < 8; b++)
				crc = crc[0] ? ((crc >> 1) ^ rcs_pkg::CRC_POLY) : (crc >> 1);
		end
		fr[n] = crc[7:0];
		fr[n + 1] = crc[15:8];
		for (int i = 0; i < n + 2; i++)
			reply_q.push_back('{fr[i], i == n + 1, 8'(coils)});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coils = '0;
			seen = 0;
			reply_q.delete();
		end else begin
			if (push && !full) begin
				if (seen < rcs_pkg::REQ_STORE_BYTES) frame_buf[seen] = rx_byte;
				if (seen < rcs_pkg::SEEN_MAX) seen++;
				if (frame_end) begin
					if (seen >= 4) serve_frame(seen);
					seen = 0;
				end
			end
			if (pop && !empty) begin
				if (reply_q.size() == 0) begin
					report("unexpected beat", tx_byte, 8'h00);
				end else begin
					if (tx_byte !== reply_q[0].data)
						report("tx_byte", tx_byte, reply_q[0].data);
					if (tx_last !== reply_q[0].last)
						report("tx_last", 8'(tx_last), 8'(reply_q[0].last));
					if (coil_levels !== reply_q[0].coils)
						report("coil_levels", coil_levels, reply_q[0].coils);
					void'(reply_q.pop_front());
				end
			end
		end
	end

	initial errors = 0;
endmodule

>>> sim/rtu_coil_slave_test.sv
// ----------------------------------------------------------------------------
// rtu_coil_slave_test
// Drives request frames into the coil server with random gaps and reply
// stalls; the checker beside the block predicts and compares reply beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtu_coil_slave_test;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic frame_end = 1'b0;
	logic pop = 1'b0;
	logic full, empty, tx_last;
	logic [7:0] tx_byte, coil_levels;
	int errors, replies_owed;

	// Stimulus phase flags shared with the receiver process.
	bit quiet = 1'b0;        // last part of the run: no idle bursts on send or receive
	bit hold_rx = 1'b0;      // ask the receiver for a long hold-off
	int beats_sent = 0;

	rtu_coil_slave i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.rx_byte(rx_byte), .frame_end(frame_end), .empty(empty), .pop(pop),
		.tx_byte(tx_byte), .tx_last(tx_last), .coil_levels(coil_levels)
	);

	rtu_coil_slave_check i_check (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.rx_byte(rx_byte), .frame_end(frame_end), .empty(empty), .pop(pop),
		.tx_byte(tx_byte), .tx_last(tx_last), .coil_levels(coil_levels),
		.errors(errors), .replies_owed(replies_owed)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Send one beat: hold push until the block takes it, then maybe idle.
	task automatic send_beat(input logic [7:0] b, input logic last);
		push <= 1'b1;
		rx_byte <= b;
		frame_end <= last;
		@(posedge clk);
		while (full) @(posedge clk);
		beats_sent++;
		// Idle in a burst now and then; drop push only when we really stall.
		if (!quiet && $urandom_range(0, 9) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic send_frame(input logic [7:0] fr[$]);
		foreach (fr[i]) send_beat(fr[i], i == fr.size() - 1);
	endtask

	// Append two bytes standing in for the request CRC (never checked).
	task automatic add_tail(ref logic [7:0] fr[$]);
		fr.push_back($urandom);
		fr.push_back($urandom);
	endtask

	// Build a well-formed request with random content, sometimes bent.
	task automatic make_request(ref logic [7:0] fr[$]);
		int kind, addr, qty, bc;
		kind = $urandom_range(0, 9);
		addr = $urandom_range(0, rcs_pkg::COIL_COUNT - 1);
		qty = $urandom_range(1, rcs_pkg::COIL_COUNT - addr);
		fr.delete();
		fr.push_back($urandom);
		if (kind < 3) begin
			fr.push_back(rcs_pkg::FC_READ_COILS);
		end else if (kind < 6) begin
			fr.push_back(rcs_pkg::FC_WRITE_COIL);
			qty = $urandom_range(0, 1) ? rcs_pkg::COIL_ON : 0;
		end else if (kind < 9) begin
			fr.push_back(rcs_pkg::FC_WRITE_COILS);
		end else begin
			fr.push_back($urandom);
		end
		// Bend the address or quantity once in a while.
		if ($urandom_range(0, 7) == 0) addr = $urandom_range(0, 65535);
		if ($urandom_range(0, 7) == 0) qty = $urandom_range(0, 65535);
		fr.push_back(addr[15:8]); fr.push_back(addr[7:0]);
		fr.push_back(qty[15:8]); fr.push_back(qty[7:0]);
		if (fr[1] == rcs_pkg::FC_WRITE_COILS) begin
			bc = (qty + 7) / 8;
			if ($urandom_range(0, 9) == 0) bc = $urandom_range(0, 3);
			fr.push_back(bc[7:0]);
			for (int i = 0; i < bc && i < 3; i++) fr.push_back($urandom);
		end
		add_tail(fr);
		// Truncate or pad now and then.
		if ($urandom_range(0, 11) == 0) fr = fr[0:$urandom_range(0, fr.size() - 1)];
		else if ($urandom_range(0, 11) == 0)
			repeat ($urandom_range(1, 20)) fr.push_back($urandom);
	endtask

	task automatic wait_drained();
		while (replies_owed != 0) @(posedge clk);
	endtask

	// Receiver: pop in random bursts; honor a long hold-off when asked.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				pop <= 1'b0;
				repeat (400) @(posedge clk);
				hold_rx = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [7:0] fr[$];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: read all coils off, set and clear, write many, faults.
		fr = '{8'h01, rcs_pkg::FC_READ_COILS, 8'h00, 8'h00, 8'h00, 8'h08};
		add_tail(fr); send_frame(fr);
		fr = '{8'hFF, rcs_pkg::FC_WRITE_COIL, 8'h00, 8'h07, 8'hFF, 8'h00};
		add_tail(fr); send_frame(fr);
		fr = '{8'h00, rcs_pkg::FC_WRITE_COILS, 8'h00, 8'h00, 8'h00, 8'h08, 8'h01, 8'hA5};
		add_tail(fr); send_frame(fr);
		fr = '{8'h11, rcs_pkg::FC_WRITE_COIL, 8'h00, 8'h00, 8'h00, 8'h00};
		add_tail(fr); send_frame(fr);
		fr = '{8'h11, rcs_pkg::FC_READ_COILS, 8'h00, 8'h00, 8'h00, 8'h08};
		add_tail(fr); send_frame(fr);
		// Unknown function, short frames, bad range, bad value.
		fr = '{8'h12, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01}; add_tail(fr); send_frame(fr);
		fr = '{8'h12, rcs_pkg::FC_READ_COILS, 8'h00}; send_frame(fr);
		fr = '{8'h12, rcs_pkg::FC_READ_COILS, 8'h00, 8'h00, 8'h00}; send_frame(fr);
		fr = '{8'h12, rcs_pkg::FC_WRITE_COILS, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01};
		send_frame(fr);
		fr = '{8'h12, rcs_pkg::FC_READ_COILS, 8'h00, 8'h00, 8'h00, 8'h00};
		add_tail(fr); send_frame(fr);
		fr = '{8'h12, rcs_pkg::FC_READ_COILS, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		add_tail(fr); send_frame(fr);
		fr = '{8'h12, rcs_pkg::FC_WRITE_COIL, 8'h00, 8'h08, 8'hFF, 8'h00};
		add_tail(fr); send_frame(fr);
		fr = '{8'h12, rcs_pkg::FC_WRITE_COIL, 8'h00, 8'h01, 8'h12, 8'h34};
		add_tail(fr); send_frame(fr);
		fr = '{8'h12, rcs_pkg::FC_WRITE_COILS, 8'h00, 8'h00, 8'h00, 8'h08, 8'h02, 8'hFF};
		add_tail(fr); send_frame(fr);
		// Byte count right but frame short of its CRC.
		fr = '{8'h12, rcs_pkg::FC_WRITE_COILS, 8'h00, 8'h00, 8'h00, 8'h08, 8'h01, 8'h55};
		send_frame(fr);
		// Long frame: well past the request store.
		fr = '{8'h13, rcs_pkg::FC_WRITE_COILS, 8'h00, 8'h02, 8'h00, 8'h03, 8'h01, 8'hFF};
		repeat (20) fr.push_back($urandom);
		send_frame(fr);
		push <= 1'b0;
		wait_drained();

		// Fill the block while the receiver holds off.
		hold_rx = 1'b1;
		repeat (6) begin
			make_request(fr);
			send_frame(fr);
		end
		push <= 1'b0;
		wait_drained();

		while (beats_sent < 300) begin
			if ($urandom_range(0, 9) == 0) begin
				fr.delete();
				repeat ($urandom_range(1, 12)) fr.push_back($urandom);
			end else begin
				make_request(fr);
			end
			if (beats_sent > 260) quiet = 1'b1;
			send_frame(fr);
			// Now and then pause until all replies are back.
			if ($urandom_range(0, 49) == 0) begin
				push <= 1'b0;
				wait_drained();
			end
		end
		push <= 1'b0;
		wait_drained();
		repeat (40) @(posedge clk);
		if (errors == 0 && replies_owed == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

>>> rtu_coil_slave.f
hw/rtl/rcs_pkg.sv
hw/rtl/rcs_front.sv
hw/rtl/rcs_job_fifo.sv
hw/rtl/rcs_back.sv
hw/rtl/rtu_coil_slave.sv
sim/rtu_coil_slave_check.sv
sim/rtu_coil_slave_test.sv
